>>> rtl/ole_pkg.sv
// Shared opcodes, status codes, defaults and port types of the ordered list engine.
package ole_pkg;

  localparam int DEF_CAPACITY     = 64;
  localparam int DEF_KEY_BITS     = 16;
  localparam int DEF_PAYLOAD_BITS = 8;

  localparam int OPC_BITS    = 4;
  localparam int POS_BITS    = 6;
  localparam int STATUS_BITS = 3;
  localparam int ECOUNT_BITS = 7;

  localparam logic [OPC_BITS-1:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [OPC_BITS-1:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [OPC_BITS-1:0] OP_POP_FRONT  = 4'd2;
  localparam logic [OPC_BITS-1:0] OP_POP_BACK   = 4'd3;
  localparam logic [OPC_BITS-1:0] OP_READ       = 4'd4;
  localparam logic [OPC_BITS-1:0] OP_WRITE      = 4'd5;
  localparam logic [OPC_BITS-1:0] OP_REMOVE     = 4'd6;
  localparam logic [OPC_BITS-1:0] OP_SORTED     = 4'd7;
  localparam logic [OPC_BITS-1:0] OP_CLEAR      = 4'd8;

  localparam logic [STATUS_BITS-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_RANGE = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_NOKEY = 3'd4;

  // write enables of the node pool
  typedef struct packed {
    logic kp;   // key and payload
    logic nx;   // next link
    logic pv;   // previous link
  } pool_we_t;

endpackage

>>> rtl/ole_node_pool.sv
// Node pool: key, payload and link memories with a registered read port.
module ole_node_pool #(
  parameter int CAPACITY     = ole_pkg::DEF_CAPACITY,
  parameter int KEY_BITS     = ole_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = ole_pkg::DEF_PAYLOAD_BITS,
  parameter int PTR_W        = $clog2(CAPACITY),
  parameter int CNT_W        = $clog2(CAPACITY + 1)
) (
  input  logic                    clk,
  input  logic [PTR_W-1:0]        rd_addr,
  input  logic [CNT_W-1:0]        fill,       // nodes at or above never had a next written
  input  ole_pkg::pool_we_t       we,
  input  logic [PTR_W-1:0]        kp_addr,
  input  logic [KEY_BITS-1:0]     kp_key,
  input  logic [PAYLOAD_BITS-1:0] kp_pay,
  input  logic [PTR_W-1:0]        nx_addr,
  input  logic [PTR_W-1:0]        nx_data,
  input  logic [PTR_W-1:0]        pv_addr,
  input  logic [PTR_W-1:0]        pv_data,
  output logic [KEY_BITS-1:0]     key_q,
  output logic [PAYLOAD_BITS-1:0] pay_q,
  output logic [PTR_W-1:0]        prev_q,
  output logic [PTR_W-1:0]        next_eff
);
  import ole_pkg::*;

  localparam logic [PTR_W-1:0] LAST = PTR_W'(CAPACITY - 1);

  logic [KEY_BITS-1:0]     key_mem [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];
  logic [PTR_W-1:0]        next_mem[CAPACITY];
  logic [PTR_W-1:0]        prev_mem[CAPACITY];

  logic [PTR_W-1:0] next_q;
  logic [PTR_W-1:0] q_addr;
  logic             fresh_q;

  always_ff @(posedge clk) begin
    if (we.kp) begin
      key_mem[kp_addr] <= kp_key;
      pay_mem[kp_addr] <= kp_pay;
    end
    if (we.nx) begin
      next_mem[nx_addr] <= nx_data;
    end
    if (we.pv) begin
      prev_mem[pv_addr] <= pv_data;
    end
  end

  always_ff @(posedge clk) begin
    key_q   <= key_mem[rd_addr];
    pay_q   <= pay_mem[rd_addr];
    next_q  <= next_mem[rd_addr];
    prev_q  <= prev_mem[rd_addr];
    q_addr  <= rd_addr;
    fresh_q <= (CNT_W'(rd_addr) >= fill);
  end

  // untouched nodes (at or above fill) read as the reset chain i -> i+1
  assign next_eff = fresh_q ? ((q_addr == LAST) ? '0 : q_addr + 1'b1) : next_q;

endmodule

>>> rtl/ordered_list_engine_unit.sv
// Top level of the ordered list engine: request sequencer around the node pool.
//
// Use: a bounded doubly linked list of (key, payload) entries. One request
// beat enters on s_t*; exactly one result beat leaves on m_t* for it.
// Request tdata: opcode, position, key_in, payload_in. Result tdata:
// status, key_out, payload_out, entry_count.
// Order of work: failed requests, clear and unused opcodes go from dispatch
// straight to the result; push, and sorted insert into an empty list, take
// a free node; pops unlink and free the node; read and write walk to the
// position; remove and sorted insert follow one link per cycle, at most the
// whole list, over the next-link memory, one registered read per node.
// One request is worked at a time; s_tready is high only when the sequencer
// is idle, but a new beat is taken while the previous result still waits.
// A stalled receiver holds m_tvalid and m_tdata; a finished request then
// waits until the result register frees.
// Reset (rst, synchronous) empties the list and rechains the free pool at
// once through a fill mark; no clearing pass is run.
module ordered_list_engine_unit #(
  parameter int CAPACITY     = ole_pkg::DEF_CAPACITY,
  parameter int KEY_BITS     = ole_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = ole_pkg::DEF_PAYLOAD_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // opcode[3:0], position[9:4], key_in, payload_in, zero fill
  input  logic [((10 + KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // status[2:0], key_out, payload_out, entry_count (7 bits), zero fill
  output logic [((10 + KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
  import ole_pkg::*;

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;
  localparam int TD_W  = ((10 + KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_WALK   = 4'd2;
  localparam logic [3:0] S_SEARCH = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_TAKE   = 4'd5;
  localparam logic [3:0] S_INS2   = 4'd6;
  localparam logic [3:0] S_UNL1   = 4'd7;
  localparam logic [3:0] S_UNL2   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [1:0] M_FRONT = 2'd0;
  localparam logic [1:0] M_BACK  = 2'd1;
  localparam logic [1:0] M_MID   = 2'd2;

  logic [3:0]              state;
  logic [OPC_BITS-1:0]     op;
  logic [POS_BITS-1:0]     pos;
  logic [KEY_BITS-1:0]     key;
  logic [PAYLOAD_BITS-1:0] pay;
  logic [1:0]              mode;

  logic [PTR_W-1:0] front, back, free_ptr, cur, prv, newn;
  logic [CNT_W-1:0] count, fill, idx;

  logic [STATUS_BITS-1:0]  res_status;
  logic [KEY_BITS-1:0]     res_key;
  logic [PAYLOAD_BITS-1:0] res_pay;

  // pool ports
  logic [PTR_W-1:0]        rd_addr, kp_addr, nx_addr, nx_data, pv_addr, pv_data;
  pool_we_t                we;
  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [PTR_W-1:0]        prev_q, next_eff;

  logic at_pos, is_last, full, key_hit, key_less;

  assign s_tready = (state == S_IDLE);
  assign at_pos   = (CMP_W'(idx) == CMP_W'(pos));
  assign is_last  = ((idx + 1'b1) == count);
  assign full     = (count == FULL_CNT);
  assign key_hit  = (key_q == key);
  assign key_less = (key < key_q);

  ole_node_pool #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W)
  ) u_pool (
    .clk     (clk),
    .rd_addr (rd_addr),
    .fill    (fill),
    .we      (we),
    .kp_addr (kp_addr),
    .kp_key  (key),
    .kp_pay  (pay),
    .nx_addr (nx_addr),
    .nx_data (nx_data),
    .pv_addr (pv_addr),
    .pv_data (pv_data),
    .key_q   (key_q),
    .pay_q   (pay_q),
    .prev_q  (prev_q),
    .next_eff(next_eff)
  );

  // Pool addressing: the read address chosen here is the node whose data
  // shows on the pool outputs in the following cycle.
  always_comb begin
    rd_addr = cur;
    we      = '0;
    kp_addr = cur;
    nx_addr = '0;
    nx_data = '0;
    pv_addr = '0;
    pv_data = '0;
    unique case (state)
      S_DISP: begin
        if (op == OP_POP_BACK) begin
          rd_addr = back;
        end else if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK ||
                     (op == OP_SORTED && count == '0)) begin
          rd_addr = free_ptr;
        end else begin
          rd_addr = front;
        end
        // clear: splice the whole list onto the free list
        if (op == OP_CLEAR && count != '0) begin
          we.nx   = 1'b1;
          nx_addr = back;
          nx_data = free_ptr;
        end
      end
      S_WALK: begin
        if (at_pos) begin
          we.kp = (op == OP_WRITE);
        end else begin
          rd_addr = next_eff;
        end
      end
      S_SEARCH: begin
        rd_addr = key_hit ? cur : next_eff;
      end
      S_SCAN: begin
        rd_addr = (key_less || is_last) ? free_ptr : next_eff;
      end
      S_TAKE: begin
        we.kp   = 1'b1;
        kp_addr = free_ptr;
        unique case (mode)
          M_FRONT: begin
            if (count != '0) begin
              we.nx   = 1'b1;
              nx_addr = free_ptr;
              nx_data = front;
              we.pv   = 1'b1;
              pv_addr = front;
              pv_data = free_ptr;
            end
          end
          M_BACK: begin
            if (count != '0) begin
              we.pv   = 1'b1;
              pv_addr = free_ptr;
              pv_data = back;
              we.nx   = 1'b1;
              nx_addr = back;
              nx_data = free_ptr;
            end
          end
          default: begin
            we.nx   = 1'b1;
            nx_addr = free_ptr;
            nx_data = cur;
            we.pv   = 1'b1;
            pv_addr = free_ptr;
            pv_data = prv;
          end
        endcase
      end
      S_INS2: begin
        we.nx   = 1'b1;
        nx_addr = prv;
        nx_data = newn;
        we.pv   = 1'b1;
        pv_addr = cur;
        pv_data = newn;
      end
      S_UNL1: begin
        // middle node: bridge its neighbours
        if (count != CNT_W'(1) && cur != front && cur != back) begin
          we.nx   = 1'b1;
          nx_addr = prev_q;
          nx_data = next_eff;
          we.pv   = 1'b1;
          pv_addr = next_eff;
          pv_data = prev_q;
        end
      end
      S_UNL2: begin
        // return the node to the head of the free list
        we.nx   = 1'b1;
        nx_addr = cur;
        nx_data = free_ptr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      back     <= '0;
      free_ptr <= '0;
      count    <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it now
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tdata[3:0];
            pos   <= s_tdata[9:4];
            key   <= s_tdata[10 +: KEY_BITS];
            pay   <= s_tdata[10 + KEY_BITS +: PAYLOAD_BITS];
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res_key <= '0;
          res_pay <= '0;
          idx     <= '0;
          cur     <= rd_addr;
          unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                mode       <= (op == OP_PUSH_FRONT) ? M_FRONT : M_BACK;
                state      <= S_TAKE;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_UNL1;
              end
            end
            OP_READ, OP_WRITE: begin
              if (CMP_W'(pos) >= CMP_W'(count)) begin
                res_status <= ST_RANGE;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_WALK;
              end
            end
            OP_REMOVE: begin
              if (count == '0) begin
                res_status <= ST_NOKEY;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_SEARCH;
              end
            end
            OP_SORTED: begin
              if (full) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else if (count == '0) begin
                res_status <= ST_OK;
                mode       <= M_BACK;
                state      <= S_TAKE;
              end else begin
                res_status <= ST_OK;
                state      <= S_SCAN;
              end
            end
            OP_CLEAR: begin
              if (count != '0) begin
                free_ptr <= front;
              end
              front      <= '0;
              back       <= '0;
              count      <= '0;
              res_status <= ST_OK;
              state      <= S_DONE;
            end
            default: begin
              res_status <= ST_OK;
              state      <= S_DONE;
            end
          endcase
        end
        S_WALK: begin
          if (at_pos) begin
            if (op == OP_READ) begin
              res_key <= key_q;
              res_pay <= pay_q;
            end
            state <= S_DONE;
          end else begin
            cur <= next_eff;
            idx <= idx + 1'b1;
          end
        end
        S_SEARCH: begin
          if (key_hit) begin
            state <= S_UNL1;
          end else if (is_last) begin
            res_status <= ST_NOKEY;
            state      <= S_DONE;
          end else begin
            cur <= next_eff;
            idx <= idx + 1'b1;
          end
        end
        S_SCAN: begin
          if (key_less) begin
            prv   <= prev_q;
            mode  <= (cur == front) ? M_FRONT : M_MID;
            state <= S_TAKE;
          end else if (is_last) begin
            mode  <= M_BACK;
            state <= S_TAKE;
          end else begin
            cur <= next_eff;
            idx <= idx + 1'b1;
          end
        end
        S_TAKE: begin
          free_ptr <= next_eff;
          if (CNT_W'(free_ptr) == fill) begin
            fill <= fill + 1'b1;
          end
          count <= count + 1'b1;
          state <= (mode == M_FRONT || mode == M_BACK) ? S_DONE : S_INS2;
          unique case (mode)
            M_FRONT: begin
              front <= free_ptr;
              if (count == '0) begin
                back <= free_ptr;
              end
            end
            M_BACK: begin
              back <= free_ptr;
              if (count == '0) begin
                front <= free_ptr;
              end
            end
            default: begin
              newn <= free_ptr;
            end
          endcase
        end
        S_INS2: begin
          state <= S_DONE;
        end
        S_UNL1: begin
          res_key <= key_q;
          res_pay <= pay_q;
          priority if (count == CNT_W'(1)) begin
            front <= '0;
            back  <= '0;
          end else if (cur == front) begin
            front <= next_eff;
          end else if (cur == back) begin
            back <= prev_q;
          end
          count <= count - 1'b1;
          state <= S_UNL2;
        end
        S_UNL2: begin
          free_ptr <= cur;
          state    <= S_DONE;
        end
        S_DONE: begin
          // hold the result until the output register frees
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= TD_W'({ECOUNT_BITS'(count), res_pay, res_key, res_status});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/ole_checker.sv
// Port checker of the ordered list engine and its bind.
module ole_port_checker #(
  parameter int CAPACITY     = ole_pkg::DEF_CAPACITY,
  parameter int KEY_BITS     = ole_pkg::DEF_KEY_BITS,
  parameter int PAYLOAD_BITS = ole_pkg::DEF_PAYLOAD_BITS
) (
  input logic clk,
  input logic rst,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((10 + KEY_BITS + PAYLOAD_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
  import ole_pkg::*;

  localparam int KP_W = KEY_BITS + PAYLOAD_BITS;

  logic [STATUS_BITS-1:0] st;
  logic [ECOUNT_BITS-1:0] ecnt;
  logic [KP_W-1:0]        kp;

  assign st   = m_tdata[STATUS_BITS-1:0];
  assign kp   = m_tdata[STATUS_BITS +: KP_W];
  assign ecnt = m_tdata[STATUS_BITS + KP_W +: ECOUNT_BITS];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (st == ST_OK || st == ST_EMPTY || st == ST_RANGE ||
                  st == ST_FULL || st == ST_NOKEY))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st != ST_OK |-> kp == '0)
    else $error("failed request returned entry data");

  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == ST_EMPTY |-> ecnt == '0)
    else $error("empty status with entries present");

  a_full_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && st == ST_FULL |-> ecnt == ECOUNT_BITS'(CAPACITY))
    else $error("full status below capacity");

endmodule

bind ordered_list_engine_unit ole_port_checker #(
  .CAPACITY    (CAPACITY),
  .KEY_BITS    (KEY_BITS),
  .PAYLOAD_BITS(PAYLOAD_BITS)
) u_ole_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

>>> tb/ole_checker.sv
// Checker for the ordered list engine: watches both channels, predicts and compares results.
`timescale 1ns / 100ps

module ole_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          fail_count,
  output int          pending
);
  import ole_pkg::*;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [15:0]            key;
    logic [7:0]             pay;
    logic [ECOUNT_BITS-1:0] cnt;
  } list_result_t;

  list_result_t awaited_results[$];

  logic [15:0] node_key [64];
  logic [7:0]  node_pay [64];
  logic [5:0]  node_next[64];
  logic [5:0]  node_prev[64];
  logic [5:0]  head_idx, tail_idx, free_idx;
  int unsigned used;

  function automatic void pool_reset();
    for (int i = 0; i < 64; i++) begin
      node_key[i]  = '0;
      node_pay[i]  = '0;
      node_prev[i] = '0;
      node_next[i] = 6'(i + 1);
    end
    head_idx = '0;
    tail_idx = '0;
    free_idx = '0;
    used     = 0;
  endfunction

  function automatic logic [5:0] grab_node(logic [15:0] k, logic [7:0] p);
    logic [5:0] n;
    n           = free_idx;
    free_idx    = node_next[n];
    node_key[n] = k;
    node_pay[n] = p;
    return n;
  endfunction

  function automatic void attach_front(logic [5:0] n);
    if (used == 0) begin
      head_idx = n;
      tail_idx = n;
    end else begin
      node_next[n]        = head_idx;
      node_prev[head_idx] = n;
      head_idx            = n;
    end
    used++;
  endfunction

  function automatic void attach_back(logic [5:0] n);
    if (used == 0) begin
      head_idx = n;
      tail_idx = n;
    end else begin
      node_prev[n]        = tail_idx;
      node_next[tail_idx] = n;
      tail_idx            = n;
    end
    used++;
  endfunction

  function automatic void detach(logic [5:0] n);
    if (used == 1) begin
      head_idx = '0;
      tail_idx = '0;
    end else if (n == head_idx) begin
      head_idx = node_next[n];
    end else if (n == tail_idx) begin
      tail_idx = node_prev[n];
    end else begin
      node_next[node_prev[n]] = node_next[n];
      node_prev[node_next[n]] = node_prev[n];
    end
    used--;
    node_next[n] = free_idx;
    free_idx     = n;
  endfunction

  function automatic list_result_t apply_request(logic [3:0] op, logic [5:0] pos,
                                                 logic [15:0] k, logic [7:0] p);
    list_result_t r;
    logic [5:0]   n;
    logic [5:0]   s;
    bit           hit;
    r   = '0;
    hit = 0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (used >= 64) r.status = ST_FULL;
        else begin
          n = grab_node(k, p);
          if (op == OP_PUSH_FRONT) attach_front(n);
          else attach_back(n);
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (used == 0) r.status = ST_EMPTY;
        else begin
          n     = (op == OP_POP_FRONT) ? head_idx : tail_idx;
          r.key = node_key[n];
          r.pay = node_pay[n];
          detach(n);
        end
      end
      OP_READ, OP_WRITE: begin
        if (pos >= used) r.status = ST_RANGE;
        else begin
          n = head_idx;
          for (int i = 0; i < pos; i++) n = node_next[n];
          if (op == OP_READ) begin
            r.key = node_key[n];
            r.pay = node_pay[n];
          end else begin
            node_key[n] = k;
            node_pay[n] = p;
          end
        end
      end
      OP_REMOVE: begin
        n = head_idx;
        for (int i = 0; i < used; i++) begin
          if (node_key[n] == k) begin
            hit = 1;
            break;
          end
          n = node_next[n];
        end
        if (!hit) r.status = ST_NOKEY;
        else begin
          r.key = node_key[n];
          r.pay = node_pay[n];
          detach(n);
        end
      end
      OP_SORTED: begin
        if (used >= 64) r.status = ST_FULL;
        else begin
          s = head_idx;
          for (int i = 0; i < used; i++) begin
            if (k < node_key[s]) begin
              hit = 1;
              break;
            end
            s = node_next[s];
          end
          n = grab_node(k, p);
          if (!hit) attach_back(n);
          else if (s == head_idx) attach_front(n);
          else begin
            node_next[node_prev[s]] = n;
            node_prev[n]            = node_prev[s];
            node_next[n]            = s;
            node_prev[s]            = n;
            used++;
          end
        end
      end
      OP_CLEAR: begin
        if (used > 0) begin
          node_next[tail_idx] = free_idx;
          free_idx            = head_idx;
        end
        head_idx = '0;
        tail_idx = '0;
        used     = 0;
      end
      default: ;
    endcase
    r.cnt = ECOUNT_BITS'(used);
    return r;
  endfunction

  assign pending = awaited_results.size();

  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (rst) begin
      pool_reset();
      awaited_results.delete();
      fail_count <= 0;
    end else begin
      if (s_tvalid && s_tready)
        awaited_results.push_back(apply_request(s_tdata[3:0], s_tdata[9:4],
                                                s_tdata[25:10], s_tdata[33:26]));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[2:0], m_tdata[18:3], m_tdata[26:19], m_tdata[33:27]};
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing outstanding");
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (got.status != want.status)
              $error("status expected %0d got %0d", want.status, got.status);
            if (got.key != want.key)
              $error("key_out expected %0h got %0h", want.key, got.key);
            if (got.pay != want.pay)
              $error("payload_out expected %0h got %0h", want.pay, got.pay);
            if (got.cnt != want.cnt)
              $error("entry_count expected %0d got %0d", want.cnt, got.cnt);
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_ordered_list_engine_unit.sv
// Testbench top for the ordered list engine: stimulus, receiver back-pressure and verdict.
`timescale 1ns / 100ps

module tb_ordered_list_engine_unit;
  import ole_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;  // idle cycles; above the long hold-off
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 80;    // beyond the longest walk

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // opcode, position, key_in, payload_in, zero fill
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;        // status, key_out, payload_out, entry_count, zero fill

  int fail_count;
  int pending;
  int idle_mode = 0;           // 0 none, 1 sender, 2 receiver, 3 both
  bit hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  ordered_list_engine_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  ole_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: stall by idle mode; hold off for a long stretch when asked.
  always @(posedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      m_tready <= ($urandom_range(0, 99) >= 48);
    end else if (idle_mode == 3) begin
      m_tready <= ($urandom_range(0, 99) >= 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one request beat and hold it until accepted; gaps only lower tvalid
  // in steps where it is not raised again.
  task automatic send_request(logic [3:0] op, logic [5:0] pos, logic [15:0] k,
                              logic [7:0] p);
    int gap_pct;
    gap_pct = (idle_mode == 1) ? 48 : (idle_mode == 3) ? 9 : 0;
    if ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, p, k, pos, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Keys drawn mostly from a narrow set so that removals and equal keys hit.
  function automatic logic [15:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(0, 7));
    if (r < 70) return 16'hFFFF - 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  task automatic random_request();
    int r;
    logic [3:0] op;
    logic [5:0] pos;
    r = $urandom_range(0, 99);
    if (r < 11) op = OP_PUSH_FRONT;
    else if (r < 22) op = OP_PUSH_BACK;
    else if (r < 37) op = OP_SORTED;
    else if (r < 45) op = OP_POP_FRONT;
    else if (r < 52) op = OP_POP_BACK;
    else if (r < 64) op = OP_READ;
    else if (r < 72) op = OP_WRITE;
    else if (r < 84) op = OP_REMOVE;
    else if (r < 86) op = OP_CLEAR;
    else if (r < 89) op = 4'($urandom_range(9, 15));
    else op = OP_PUSH_BACK;
    pos = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 12));
    send_request(op, pos, pick_key(), 8'($urandom));
  endtask

  // Fill towards a full pool, then a few more to hit the full status.
  task automatic fill_burst();
    logic [3:0] op;
    for (int i = 0; i < 68; i++) begin
      case ($urandom_range(0, 2))
        0: op = OP_PUSH_FRONT;
        1: op = OP_PUSH_BACK;
        default: op = OP_SORTED;
      endcase
      send_request(op, 6'($urandom), pick_key(), 8'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty-list cases, unused opcode, extremes, equal keys.
    send_request(OP_POP_FRONT,  6'd0,  16'h0000, 8'h00);
    send_request(OP_POP_BACK,   6'd0,  16'h0000, 8'h00);
    send_request(OP_READ,       6'd0,  16'h0000, 8'h00);
    send_request(OP_WRITE,      6'd63, 16'hFFFF, 8'hFF);
    send_request(OP_REMOVE,     6'd0,  16'h1234, 8'h00);
    send_request(OP_CLEAR,      6'd0,  16'h0000, 8'h00);
    send_request(4'd15,         6'd63, 16'hFFFF, 8'hFF);
    send_request(OP_PUSH_FRONT, 6'd0,  16'hFFFF, 8'hFF);
    send_request(OP_PUSH_BACK,  6'd0,  16'h0000, 8'h00);
    send_request(OP_SORTED,     6'd0,  16'h0005, 8'hA1);
    send_request(OP_SORTED,     6'd0,  16'h0005, 8'hA2);
    send_request(OP_SORTED,     6'd0,  16'h0000, 8'hA3);
    send_request(OP_SORTED,     6'd0,  16'hFFFF, 8'hA4);
    send_request(OP_READ,       6'd2,  16'h0000, 8'h00);
    send_request(OP_READ,       6'd3,  16'h0000, 8'h00);
    send_request(OP_READ,       6'd63, 16'h0000, 8'h00);
    send_request(OP_WRITE,      6'd1,  16'hAAAA, 8'h55);
    send_request(OP_READ,       6'd1,  16'h0000, 8'h00);
    send_request(OP_REMOVE,     6'd0,  16'h0005, 8'h00);
    send_request(OP_REMOVE,     6'd0,  16'h7777, 8'h00);
    send_request(OP_POP_BACK,   6'd0,  16'h0000, 8'h00);
    send_request(OP_POP_FRONT,  6'd0,  16'h0000, 8'h00);
    send_request(OP_CLEAR,      6'd0,  16'h0000, 8'h00);
    send_request(OP_READ,       6'd0,  16'h0000, 8'h00);

    // Random phases, one per idle mode; the first one also holds off the
    // receiver while a fill burst keeps the sender offering.
    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = phase;
      if (phase == 0) hold_request = 1;
      fill_burst();
      for (int i = 0; i < 55; i++) random_request();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
